// File: rtl/efr_pkg.sv
// ----------------------------------------------------------------------------
// efr_pkg
// shared widths, register indexes, reset values, frame phase codes and input
// item kinds for the escaped frame receiver
// ----------------------------------------------------------------------------
package efr_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int DATA_W        = 8;
  localparam int INDEX_W       = 6;
  localparam int FRAME_W       = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int PHASE_W       = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_CODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_CODE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_CODE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_QUIET_TICKS = 2'd3;

  // register reset values
  localparam logic [DATA_W-1:0] START_CODE_RST  = 8'd126;
  localparam logic [DATA_W-1:0] END_CODE_RST    = 8'd125;
  localparam logic [DATA_W-1:0] ESCAPE_CODE_RST = 8'd124;
  localparam logic [DATA_W-1:0] QUIET_TICKS_RST = 8'd10;

  // frame phase
  localparam logic [PHASE_W-1:0] PH_IDLE   = 2'd0;
  localparam logic [PHASE_W-1:0] PH_NORMAL = 2'd1;
  localparam logic [PHASE_W-1:0] PH_ESCAPE = 2'd2;
  localparam logic [PHASE_W-1:0] PH_CLOSED = 2'd3;

  // input item kinds
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

endpackage

// File: rtl/efr_if.sv
// ----------------------------------------------------------------------------
// efr channel interfaces
// input item, result item and configuration write channels
// ----------------------------------------------------------------------------
interface efr_in_if;
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic [efr_pkg::DATA_W-1:0] rx_byte;

  modport source (output valid, output mode, output rx_byte, input ready);
  modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

interface efr_out_if;
  logic                        valid;
  logic                        ready;
  logic [efr_pkg::DATA_W-1:0]  payload_byte;
  logic [efr_pkg::INDEX_W-1:0] byte_index;
  logic                        is_last;
  logic [efr_pkg::FRAME_W-1:0] frame_number;

  modport source (output valid, output payload_byte, output byte_index,
                  output is_last, output frame_number, input ready);
  modport sink   (input valid, input payload_byte, input byte_index,
                  input is_last, input frame_number, output ready);
endinterface

interface efr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [efr_pkg::CFG_IDX_W-1:0] index;
  logic [efr_pkg::DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/efr_store.sv
// ----------------------------------------------------------------------------
// efr_store
// frame byte store, one write port and one read port, registered read data
// ----------------------------------------------------------------------------
module efr_store #(
  parameter int DEPTH = efr_pkg::DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [efr_pkg::DATA_W-1:0] wdata,
  input  logic                       re,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [efr_pkg::DATA_W-1:0] rdata
);

  logic [efr_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/escaped_frame_receiver_with_timeout.sv
// ----------------------------------------------------------------------------
// escaped_frame_receiver_with_timeout
// byte-stuffed frame receiver: start/escape/end decoding into a frame store,
// quiet timer on input ticks, payload delivery after the line goes quiet
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          payload
//  rx_in     in   valid / ready      mode, rx_byte
//  frm_out   out  valid / ready      payload_byte, byte_index, is_last,
//                                    frame_number
//  cfg       in   valid / ready      index, data (ready tied high)
//
//  a received byte or a tick that delivers nothing leaves rx_in.ready high
//  a delivering tick with n payload bytes keeps rx_in.ready low until the last
//    beat is loaded: each beat is one read of the frame store port plus one load
//    of the output register, and the load waits while frm_out stalls
//  the last beat may still sit in the output register while the next item
//    is accepted
//  synchronous reset clears control state; the frame store has no reset and
//    needs no clearing pass
//
module escaped_frame_receiver_with_timeout #(
  parameter int BUFFER_DEPTH = efr_pkg::DEPTH_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  efr_in_if.sink     rx_in,
  efr_out_if.source  frm_out,
  efr_cfg_if.sink    cfg
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int CW = $clog2(BUFFER_DEPTH + 1);

  // delivery sequencer
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FETCH = 2'd1;
  localparam logic [1:0] S_LOAD  = 2'd2;

  logic [1:0] state;

  // configuration registers
  logic [efr_pkg::DATA_W-1:0] start_code;
  logic [efr_pkg::DATA_W-1:0] end_code;
  logic [efr_pkg::DATA_W-1:0] escape_code;
  logic [efr_pkg::DATA_W-1:0] quiet_ticks;

  // frame state
  logic [efr_pkg::PHASE_W-1:0] phase;
  logic [efr_pkg::DATA_W-1:0]  quiet_timer;
  logic [CW-1:0]               byte_count;
  logic [efr_pkg::FRAME_W-1:0] frames_done;
  logic [CW-1:0]               idx;

  // output register
  logic                        out_valid;
  logic [efr_pkg::DATA_W-1:0]  out_byte;
  logic [efr_pkg::INDEX_W-1:0] out_index;
  logic                        out_last;
  logic [efr_pkg::FRAME_W-1:0] out_frame;

  // store ports
  logic                       st_we;
  logic [AW-1:0]              st_waddr;
  logic                       st_re;
  logic [AW-1:0]              st_raddr;
  logic [efr_pkg::DATA_W-1:0] st_rdata;

  logic in_fire;
  logic out_free;
  logic is_tick;
  logic timer_zero;
  logic start_hit;
  logic room;
  logic store_now;
  logic deliver;
  logic last_beat;

  assign rx_in.ready = (state == S_IDLE);
  assign cfg.ready   = 1'b1;
  assign in_fire     = rx_in.valid && rx_in.ready;
  assign out_free    = !out_valid || frm_out.ready;

  assign is_tick    = (rx_in.mode == efr_pkg::MODE_TICK);
  assign timer_zero = (quiet_timer == '0);
  assign start_hit  = timer_zero && (rx_in.rx_byte == start_code);
  assign room       = (byte_count < CW'(BUFFER_DEPTH));

  // a byte lands in the store on a start after a quiet line, or, with room, on a
  // literal after escape or any non-escape byte in a normal frame (end byte included)
  always_comb begin
    store_now = 1'b0;
    if (in_fire && !is_tick) begin
      if (start_hit) begin
        store_now = 1'b1;
      end else if (phase == efr_pkg::PH_NORMAL) begin
        store_now = (rx_in.rx_byte != escape_code) && room;
      end else if (phase == efr_pkg::PH_ESCAPE) begin
        store_now = room;
      end
    end
  end

  // quiet line, frame closed and long enough: start streaming
  assign deliver = in_fire && is_tick && timer_zero && (phase == efr_pkg::PH_CLOSED)
                   && (byte_count > CW'(2));

  // a start byte always writes entry zero
  assign st_we    = store_now;
  assign st_waddr = start_hit ? '0 : AW'(byte_count);
  assign st_re    = (state == S_FETCH);
  // payload skips the stored start byte
  assign st_raddr = AW'(idx + 1'b1);
  assign last_beat = ((idx + 1'b1) == byte_count);

  efr_store #(
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (rx_in.rx_byte),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      start_code  <= efr_pkg::START_CODE_RST;
      end_code    <= efr_pkg::END_CODE_RST;
      escape_code <= efr_pkg::ESCAPE_CODE_RST;
      quiet_ticks <= efr_pkg::QUIET_TICKS_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        efr_pkg::REG_START_CODE:  start_code  <= cfg.data;
        efr_pkg::REG_END_CODE:    end_code    <= cfg.data;
        efr_pkg::REG_ESCAPE_CODE: escape_code <= cfg.data;
        efr_pkg::REG_QUIET_TICKS: quiet_ticks <= cfg.data;
        default: ;
      endcase
    end
  end

  // frame decoding and quiet timer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= efr_pkg::PH_IDLE;
      quiet_timer <= '0;
      byte_count  <= '0;
      frames_done <= '0;
    end else if (in_fire) begin
      if (is_tick) begin
        if (!timer_zero) begin
          quiet_timer <= quiet_timer - 1'b1;
        end else if (phase == efr_pkg::PH_CLOSED) begin
          phase <= efr_pkg::PH_IDLE;
          // short frames vanish silently
          if (byte_count > CW'(2)) begin
            byte_count  <= byte_count - CW'(2);
            frames_done <= frames_done + 1'b1;
          end
        end
      end else if (start_hit) begin
        // restarts even mid-frame or after an escape, once the quiet timer has run out
        byte_count  <= CW'(1);
        quiet_timer <= quiet_ticks;
        phase       <= efr_pkg::PH_NORMAL;
      end else if (phase == efr_pkg::PH_NORMAL) begin
        quiet_timer <= quiet_ticks;
        if (store_now) begin
          byte_count <= byte_count + 1'b1;
        end
        // escape meaning wins over end
        if (rx_in.rx_byte == escape_code) begin
          phase <= efr_pkg::PH_ESCAPE;
        end else if (rx_in.rx_byte == end_code) begin
          phase <= efr_pkg::PH_CLOSED;
        end
      end else if (phase == efr_pkg::PH_ESCAPE) begin
        quiet_timer <= quiet_ticks;
        if (store_now) begin
          byte_count <= byte_count + 1'b1;
        end
        phase <= efr_pkg::PH_NORMAL;
      end
    end
  end

  // delivery: fetch one entry, then load it into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      // a load wins over the drain of the previous beat
      if (state == S_LOAD && out_free) begin
        out_valid <= 1'b1;
      end else if (frm_out.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (deliver) begin
            idx   <= '0;
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          if (out_free) begin
            if (last_beat) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_FETCH;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output payload, no reset needed
  always_ff @(posedge clk) begin
    if (state == S_LOAD && out_free) begin
      out_byte  <= st_rdata;
      out_index <= efr_pkg::INDEX_W'(idx);
      out_last  <= last_beat;
      out_frame <= frames_done;
    end
  end

  assign frm_out.valid        = out_valid;
  assign frm_out.payload_byte = out_byte;
  assign frm_out.byte_index   = out_index;
  assign frm_out.is_last      = out_last;
  assign frm_out.frame_number = out_frame;

  // an open or closed frame always holds at least its start byte
  a_frame_nonempty: assert property (@(posedge clk) disable iff (rst)
    (phase != efr_pkg::PH_IDLE) |-> (byte_count != '0))
    else $error("frame open with empty store");

  // the read pointer never passes the payload length while streaming
  a_idx_in_frame: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> ((idx + 1'b1) <= byte_count))
    else $error("delivery index beyond stored bytes");

  // the frame counter moves only when a delivery starts
  a_frames_done_step: assert property (@(posedge clk) disable iff (rst)
    !deliver |=> $stable(frames_done))
    else $error("frame counter moved without delivery");

  // no input is taken while a frame is streaming out
  a_no_input_streaming: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH || state == S_LOAD) |-> !rx_in.ready)
    else $error("input accepted during delivery");

endmodule
